FILE: src/vtpd_pkg.sv
// Shared constants and types for the vertex transform with perspective divide.
`default_nettype none
package vtpd_pkg;
  localparam int FRAC_BITS = 16;
  localparam int QB        = 33;             // quotient magnitude bits
  localparam int NUM_W     = 32 + FRAC_BITS; // dividend magnitude width
  localparam int PIPE_LEN  = 4 + QB;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  localparam logic [31:0] FIX_ONE = 32'(64'd1 << FRAC_BITS);

  typedef logic signed [31:0] fix_t;

  typedef struct packed {
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] tz;
    logic        wz;
    logic        sat;
    logic [2:0]  neg;
  } side_t;
endpackage
`default_nettype wire

FILE: src/vtpd_matrix_mem.sv
// Matrix memory: four rows of four elements, registered read, identity until written.
`default_nettype none
module vtpd_matrix_mem
  import vtpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        we,
  input  wire logic [1:0]  row,
  input  wire logic [1:0]  col,
  input  wire logic [31:0] wdata,
  input  wire logic        rd_en,
  output fix_t             m [16]
);
  logic [3:0][31:0] mem [4];
  logic [3:0][31:0] rd_row [4];
  logic [15:0]      elem_vld;
  logic [15:0]      rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[row][col] <= wdata;
    end
    if (rd_en) begin
      for (int r = 0; r < 4; r++) rd_row[r] <= mem[r];
      rd_vld <= elem_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_vld <= '0;
    end else if (we) begin
      elem_vld[{row, col}] <= 1'b1;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (rd_vld[r*4+c]) m[r*4+c] = rd_row[r][c];
        else if (r == c)   m[r*4+c] = FIX_ONE;
        else               m[r*4+c] = '0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/vtpd_transform.sv
// Row vector times matrix: product stage, then column sums with floor shift and clamp.
`default_nettype none
module vtpd_transform
  import vtpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  fix_t      v [4],
  input  fix_t      m [16],
  output fix_t      t [4],
  output logic      sat
);
  logic signed [63:0] prod [4][4];
  logic signed [65:0] sum  [4];
  logic signed [65:0] sh   [4];
  logic [3:0]         csat;
  fix_t               tc   [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++)
        for (int k = 0; k < 4; k++)
          prod[j][k] <= v[k] * m[k*4+j];
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum[j] = 66'(prod[j][0]) + 66'(prod[j][1]) + 66'(prod[j][2]) + 66'(prod[j][3]);
      sh[j]  = sum[j] >>> FRAC_BITS;
      csat[j] = !((&sh[j][65:31]) || (~|sh[j][65:31]));
      if (csat[j]) tc[j] = sh[j][65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else         tc[j] = sh[j][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) t[j] <= tc[j];
      sat <= |csat;
    end
  end
endmodule
`default_nettype wire

FILE: src/vtpd_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow precheck.
`default_nettype none
module vtpd_divider
  import vtpd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [31:0]      den,
  output logic [QB-1:0]         q,
  output logic                  ovf
);
  logic [31:0]   r    [QB+1];
  logic [QB-1:0] lowb [QB+1];
  logic [31:0]   d    [QB+1];
  logic [QB-1:0] qq   [QB+1];
  logic          ov   [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]    <= 32'(num[NUM_W-1:QB]);
      lowb[0] <= num[QB-1:0];
      d[0]    <= den;
      qq[0]   <= '0;
      ov[0]   <= 32'(num[NUM_W-1:QB]) >= den;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [32:0] rr;
    logic        ge;
    assign rr = {r[i], lowb[i][QB-1]};
    assign ge = rr >= {1'b0, d[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        r[i+1]    <= ge ? 32'(rr - {1'b0, d[i]}) : rr[31:0];
        lowb[i+1] <= {lowb[i][QB-2:0], 1'b0};
        d[i+1]    <= d[i];
        qq[i+1]   <= {qq[i][QB-2:0], ge};
        ov[i+1]   <= ov[i];
      end
    end
  end

  assign q   = qq[QB];
  assign ovf = ov[QB];
endmodule
`default_nettype wire

FILE: src/vertex_transform_perspective_divide.sv
// Vertex transform by a 4x4 matrix with homogeneous divide, Q16.16 fixed point.
//
// Input stream (s_axis): tuser = kind. Kind load writes matrix element
// (row, col); it gives no result. Kind vertex gives one result transfer.
// Output stream (m_axis): x, y, z, w and the w_zero / saturated flags.
// One item is taken per cycle while the skid register is empty. A vertex result
// passes the matrix memory read, which shares the transfer edge, the product and
// column-sum registers, the divider (precheck register plus one quotient bit per
// stage over 33 stages) and the output register.
// A load is visible to the next transfer.
// Reset returns the matrix to identity (per-element valid bits, no sweep)
// and empties the pipeline.
// When the receiver stalls, the output register holds its result and one
// more result enters a skid register; the pipeline then halts and s_axis
// tready drops until the skid register drains.
`default_nettype none
module vertex_transform_perspective_divide
  import vtpd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [167:0] s_axis_tdata,  // row, col, element, in_x, in_y, in_z, in_w, pad
  input  wire logic         s_axis_tuser,  // kind
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata,  // out_x, out_y, out_z, out_w
  output logic [1:0]        m_axis_tuser   // w_zero, saturated
);
  logic                en;
  logic                in_acc;
  logic [PIPE_LEN-1:0] vld;
  fix_t                v [4];
  fix_t                m [16];
  fix_t                t [4];
  logic                tsat;
  side_t               sb [QB+1];
  logic [QB-1:0]       q [3];
  logic [2:0]          qovf;
  logic [31:0]         tmag [4];
  logic [31:0]         res [3];
  logic [2:0]          rsat;
  logic [129:0]        fin;
  logic                m_valid, skid_valid;
  logic [129:0]        m_data, skid_data;
  logic                incoming;

  assign en            = !skid_valid;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && en;

  vtpd_matrix_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (in_acc && s_axis_tuser == KIND_LOAD),
    .row   (s_axis_tdata[1:0]),
    .col   (s_axis_tdata[3:2]),
    .wdata (s_axis_tdata[35:4]),
    .rd_en (en),
    .m     (m)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      v[0] <= s_axis_tdata[67:36];
      v[1] <= s_axis_tdata[99:68];
      v[2] <= s_axis_tdata[131:100];
      v[3] <= s_axis_tdata[163:132];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LEN-2:0], in_acc && s_axis_tuser == KIND_VERTEX};
    end
  end

  vtpd_transform u_xf (
    .clk (clk),
    .en  (en),
    .v   (v),
    .m   (m),
    .t   (t),
    .sat (tsat)
  );

  always_comb begin
    for (int j = 0; j < 4; j++) tmag[j] = t[j][31] ? 32'(-t[j]) : t[j];
  end

  for (genvar j = 0; j < 3; j++) begin : g_div
    vtpd_divider u_div (
      .clk (clk),
      .en  (en),
      .num ({tmag[j], FRAC_BITS'(0)}),
      .den (tmag[3]),
      .q   (q[j]),
      .ovf (qovf[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= '{tx: t[0], ty: t[1], tz: t[2], wz: (t[3] == '0), sat: tsat,
                 neg: {t[2][31] ^ t[3][31], t[1][31] ^ t[3][31], t[0][31] ^ t[3][31]}};
      for (int i = 1; i <= QB; i++) sb[i] <= sb[i-1];
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (sb[QB].neg[j]) begin
        rsat[j] = qovf[j] || (q[j] > QB'(33'h1_0000_0000 >> 1));
        res[j]  = rsat[j] ? 32'h8000_0000 : 32'(-q[j]);
      end else begin
        rsat[j] = qovf[j] || (q[j] > QB'(32'h7FFF_FFFF));
        res[j]  = rsat[j] ? 32'h7FFF_FFFF : q[j][31:0];
      end
    end
    if (sb[QB].wz) begin
      fin = {sb[QB].sat, 1'b1, 32'h0, sb[QB].tz, sb[QB].ty, sb[QB].tx};
    end else begin
      fin = {sb[QB].sat | (|rsat), 1'b0, FIX_ONE, res[2], res[1], res[0]};
    end
  end

  assign incoming = en && vld[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_valid || m_axis_tready) begin
      if (skid_valid) begin
        m_valid    <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_valid <= incoming;
      end
    end else if (incoming) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_valid || m_axis_tready) begin
      m_data <= skid_valid ? skid_data : fin;
    end else if (incoming) begin
      skid_data <= fin;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data[127:0];
  assign m_axis_tuser  = m_data[129:128];

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_valid) else $error("skid register filled ahead of output register");
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !m_axis_tready && incoming) |=> skid_valid)
    else $error("result lost while output stalled");
  a_wzero_w: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[127:96] == '0))
    else $error("w_zero result with nonzero w");
  a_div_w: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[127:96] == FIX_ONE))
    else $error("divided result with w not one");
endmodule
`default_nettype wire

FILE: tb/sv/vtpd_checker.sv
// Checker for the vertex transform block: watches both streams, predicts results, compares.
`timescale 1ns / 100ps
`default_nettype none
module vtpd_checker
  import vtpd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [167:0] s_axis_tdata,
  input  wire logic         s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [127:0] m_axis_tdata,
  input  wire logic [1:0]   m_axis_tuser,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        wz;
    logic        sat;
  } vert_out_t;

  logic signed [31:0] mat [16];
  vert_out_t projected_q [$];

  function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic vert_out_t project_vertex(input logic [167:0] d);
    logic signed [63:0] v [4];
    logic signed [63:0] t [4];
    logic signed [95:0] acc;
    logic signed [95:0] num;
    logic sat;
    vert_out_t r;
    sat = 1'b0;
    for (int k = 0; k < 4; k++) v[k] = 64'(signed'(d[36 + 32*k +: 32]));
    for (int j = 0; j < 4; j++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) acc += 96'(v[k]) * 96'(mat[k*4 + j]);
      t[j] = clamp_q(64'(acc >>> FRAC_BITS), sat);
    end
    if (t[3] == 0) begin
      r.x = t[0][31:0];
      r.y = t[1][31:0];
      r.z = t[2][31:0];
      r.w = '0;
      r.wz = 1'b1;
    end else begin
      num = 96'(t[0]) <<< FRAC_BITS;
      r.x = 32'(clamp_q(64'(num / 96'(t[3])), sat));
      num = 96'(t[1]) <<< FRAC_BITS;
      r.y = 32'(clamp_q(64'(num / 96'(t[3])), sat));
      num = 96'(t[2]) <<< FRAC_BITS;
      r.z = 32'(clamp_q(64'(num / 96'(t[3])), sat));
      r.w = FIX_ONE;
      r.wz = 1'b0;
    end
    r.sat = sat;
    return r;
  endfunction

  assign pending = projected_q.size();

  always @(posedge clk) begin
    vert_out_t got, want;
    if (rst) begin
      for (int i = 0; i < 16; i++) mat[i] <= (i % 5 == 0) ? FIX_ONE : '0;
      projected_q.delete();
      errors <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == KIND_LOAD)
          mat[{s_axis_tdata[1:0], s_axis_tdata[3:2]}] <= s_axis_tdata[35:4];
        else projected_q.push_back(project_vertex(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
               m_axis_tdata[127:96], m_axis_tuser[0], m_axis_tuser[1]};
        if (projected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result transfer %h", got);
          errors <= errors + 1;
        end else begin
          want = projected_q.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display({"mismatch: exp x=%h y=%h z=%h w=%h wz=%b sat=%b",
                        " / got x=%h y=%h z=%h w=%h wz=%b sat=%b"},
                       want.x, want.y, want.z, want.w, want.wz, want.sat,
                       got.x, got.y, got.z, got.w, got.wz, got.sat);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: tb/sv/tb_vertex_transform_perspective_divide.sv
// Top of the vertex transform testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_vertex_transform_perspective_divide;
  import vtpd_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic         s_axis_tuser = KIND_LOAD;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  int           errors;
  int           pending;
  int           send_idle = 0;
  int           recv_stall = 0;

  always #4 clk = ~clk;

  vertex_transform_perspective_divide i_dut (.*);
  vtpd_checker i_chk (.*);

  function automatic logic [31:0] rand_fix();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return FIX_ONE;
      4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      5: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)) <<< 4;
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);

  task automatic send(input logic kind, input logic [1:0] r, input logic [1:0] c,
                      input logic [31:0] e, input logic [31:0] x, input logic [31:0] y,
                      input logic [31:0] z, input logic [31:0] w);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0, w, z, y, x, e, c, r};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic load(input int r, input int c, input logic [31:0] e);
    send(KIND_LOAD, 2'(r), 2'(c), e, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic vert(input logic [31:0] x, input logic [31:0] y,
                      input logic [31:0] z, input logic [31:0] w);
    send(KIND_VERTEX, 2'($urandom()), 2'($urandom()), $urandom(), x, y, z, w);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int mode;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // identity, extremes, zero w, overflow
    vert(FIX_ONE, 32'h0002_0000, 32'hffff_0000, FIX_ONE);
    vert(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, FIX_ONE);
    vert(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0);
    vert(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1);
    vert(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    vert(32'h0000_8000, 32'hffff_8000, 32'h1, 32'hffff_ffff);
    load(3, 3, 32'h7fff_ffff);
    load(0, 0, 32'h8000_0000);
    load(3, 0, 32'h7fff_ffff);
    vert(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    vert(32'h8000_0000, 32'h1, 32'h0, 32'h8000_0000);
    load(3, 3, 32'h0);
    load(3, 0, 32'h0);
    vert(32'h1234_5678, 32'h0, 32'h0, FIX_ONE);
    load(2, 3, FIX_ONE);
    vert(32'h0, 32'h0, 32'h0003_0000, 32'h0);
    vert(32'h0, 32'h0, 32'hfffd_0000, 32'h0);
    drain();
    for (int i = 0; i < 16; i++) load(i / 4, i % 4, (i % 5 == 0) ? FIX_ONE : 32'h0);
    for (int n = 0; n < 1950; n++) begin
      if (n % 250 == 0) begin
        mode = (n / 250) % 4;
        send_idle  = (mode == 1 || mode == 3) ? ((mode == 1) ? 66 : 13) : 0;
        recv_stall = (mode == 2 || mode == 3) ? ((mode == 2) ? 66 : 13) : 0;
        if (n == 1000) drain();
      end
      if ($urandom_range(0, 99) < 12) load($urandom_range(0, 3), $urandom_range(0, 3), rand_fix());
      else vert(rand_fix(), rand_fix(), rand_fix(), rand_fix());
    end
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
